// File: design/cpl_pkg.sv
// Shared constants, types and helpers for the clip player.
`default_nettype none

package cpl_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);

    localparam int VOL_W    = 7;
    localparam int COUNT_W  = 13;
    localparam int SAMPLE_W = 16;
    localparam int FIELD_ADDR_W = 12;

    localparam logic [VOL_W-1:0] VOL_FULL = VOL_W'(100);

    // Division by 100 as a multiply by 2^29 / 100 rounded up, a reciprocal of 100 scaled by 2^29.
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(((64'd1 << RECIP_SHIFT) + 99) / 100);

    localparam int MAG_W  = SAMPLE_W + 1;
    localparam int PROD_W = 22;

    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [2:0] {
        MODE_LOAD = 3'd0,
        MODE_ONCE = 3'd1,
        MODE_LOOP = 3'd2,
        MODE_STOP = 3'd3,
        MODE_TICK = 3'd4
    } t_mode;

    // One queued operation for the back end: a store write or a tick.
    typedef struct packed {
        logic                is_tick;
        t_addr               addr;
        logic [SAMPLE_W-1:0] data;
        logic                playing;
        logic                looping;
        logic                pass_end;
    } t_qent;

    typedef struct packed {
        logic playing;
        logic looping;
        logic pass_end;
    } t_flags;

endpackage

`default_nettype wire

// File: design/cpl_front.sv
// Command front end: accepts transactions, tracks clip and loop state, issues queue entries.
`default_nettype none

module cpl_front (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  wire  [2:0]                   i_mode,
    input  wire  [cpl_pkg::FIELD_ADDR_W-1:0] i_start_addr,
    input  wire  [cpl_pkg::COUNT_W-1:0]  i_frame_count,
    input  wire  [cpl_pkg::SAMPLE_W-1:0] i_load_sample,
    input  wire                          i_q_full,
    output logic                         o_in_stall,
    output logic                         o_push,
    output cpl_pkg::t_qent               o_push_ent
);
    import cpl_pkg::*;

    t_addr              r_play_pos,   n_play_pos;
    logic [COUNT_W-1:0] r_play_left,  n_play_left;
    logic               r_cur_loop,   n_cur_loop;
    t_addr              r_loop_start, n_loop_start;
    logic [COUNT_W-1:0] r_loop_len,   n_loop_len;
    logic               r_loop_act,   n_loop_act;
    logic               r_loop_susp,  n_loop_susp;

    logic  accept;
    t_addr addr;
    logic  active;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign addr       = t_addr'(i_start_addr);
    assign active     = (r_play_left != '0);

    always_comb begin
        n_play_pos   = r_play_pos;
        n_play_left  = r_play_left;
        n_cur_loop   = r_cur_loop;
        n_loop_start = r_loop_start;
        n_loop_len   = r_loop_len;
        n_loop_act   = r_loop_act;
        n_loop_susp  = r_loop_susp;
        o_push       = 1'b0;
        o_push_ent   = '0;
        o_push_ent.addr = addr;
        o_push_ent.data = i_load_sample;

        if (accept) begin
            case (t_mode'(i_mode))
                MODE_LOAD: begin
                    o_push = 1'b1;
                end
                MODE_ONCE: begin
                    if (i_frame_count != '0) begin
                        if (r_loop_act && !r_loop_susp) begin
                            n_loop_susp = 1'b1;
                        end else begin
                            n_loop_act = 1'b0;
                        end
                        n_cur_loop  = 1'b0;
                        n_play_pos  = addr;
                        n_play_left = i_frame_count;
                    end
                end
                MODE_LOOP: begin
                    if (i_frame_count != '0) begin
                        n_loop_start = addr;
                        n_loop_len   = i_frame_count;
                        n_loop_act   = 1'b1;
                        n_loop_susp  = 1'b0;
                        n_cur_loop   = 1'b1;
                        n_play_pos   = addr;
                        n_play_left  = i_frame_count;
                    end
                end
                MODE_STOP: begin
                    n_play_pos  = '0;
                    n_play_left = '0;
                    n_cur_loop  = 1'b0;
                    n_loop_act  = 1'b0;
                    n_loop_susp = 1'b0;
                end
                MODE_TICK: begin
                    o_push              = 1'b1;
                    o_push_ent.is_tick  = 1'b1;
                    o_push_ent.addr     = r_play_pos;
                    o_push_ent.playing  = active;
                    o_push_ent.looping  = active && r_cur_loop;
                    o_push_ent.pass_end = (r_play_left == COUNT_W'(1));
                    if (active) begin
                        n_play_pos  = r_play_pos + t_addr'(1);
                        n_play_left = r_play_left - COUNT_W'(1);
                        if (r_play_left == COUNT_W'(1)) begin
                            if (r_cur_loop) begin
                                n_play_pos  = r_loop_start;
                                n_play_left = r_loop_len;
                            end else if (r_loop_susp) begin
                                n_loop_susp = 1'b0;
                                n_loop_act  = 1'b1;
                                n_cur_loop  = 1'b1;
                                n_play_pos  = r_loop_start;
                                n_play_left = r_loop_len;
                            end else begin
                                n_cur_loop = 1'b0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_pos   <= '0;
            r_play_left  <= '0;
            r_cur_loop   <= 1'b0;
            r_loop_start <= '0;
            r_loop_len   <= '0;
            r_loop_act   <= 1'b0;
            r_loop_susp  <= 1'b0;
        end else begin
            r_play_pos   <= n_play_pos;
            r_play_left  <= n_play_left;
            r_cur_loop   <= n_cur_loop;
            r_loop_start <= n_loop_start;
            r_loop_len   <= n_loop_len;
            r_loop_act   <= n_loop_act;
            r_loop_susp  <= n_loop_susp;
        end
    end

endmodule

`default_nettype wire

// File: design/cpl_queue.sv
// Short queue that decouples the command front end from the sample back end.
`default_nettype none

module cpl_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  cpl_pkg::t_qent  i_push_ent,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_valid,
    output cpl_pkg::t_qent  o_head
);
    import cpl_pkg::*;

    t_qent              r_ent [QDEPTH];
    logic [QAW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [QAW:0]       r_count,  n_count;
    logic               do_pop;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_ent[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + QAW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + QAW'(1);
        end
        if (i_push && !do_pop) begin
            n_count = r_count + (QAW+1)'(1);
        end else if (!i_push && do_pop) begin
            n_count = r_count - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr_ptr] <= i_push_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// File: design/cpl_back.sv
// Sample back end: store access, volume scaling pipeline and output register.
`default_nettype none

module cpl_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_q_valid,
    input  cpl_pkg::t_qent               i_q_ent,
    output logic                         o_pop,
    input  wire  [cpl_pkg::VOL_W-1:0]    i_vol,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [cpl_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                         o_playing,
    output logic                         o_looping,
    output logic                         o_pass_end,
    output logic                         o_amp_enable
);
    import cpl_pkg::*;

    logic [SAMPLE_W-1:0] r_mem [STORE_DEPTH];

    logic                r_a_valid;
    logic [SAMPLE_W-1:0] r_a_rd;
    t_flags              r_a_flags;

    logic                r_b_valid;
    logic [PROD_W-1:0]   r_b_prod;
    logic                r_b_neg;
    t_flags              r_b_flags;

    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_sample;
    t_flags              r_o_flags;
    logic                r_o_amp;

    logic                    o_ready, b_ready, a_ready;
    logic                    pop_load, pop_tick;
    logic [MAG_W-1:0]        a_mag;
    logic [PROD_W-1:0]       a_prod;
    logic [PROD_W+RECIP_W-1:0] b_full;
    logic [SAMPLE_W-1:0]     b_quot;
    logic [SAMPLE_W-1:0]     b_sample;

    assign o_ready  = !r_o_valid || !i_out_stall;
    assign b_ready  = !r_b_valid || o_ready;
    assign a_ready  = !r_a_valid || b_ready;
    assign pop_load = i_q_valid && !i_q_ent.is_tick;
    assign pop_tick = i_q_valid && i_q_ent.is_tick && a_ready;
    assign o_pop    = pop_load || pop_tick;

    always_ff @(posedge i_clk) begin
        if (pop_load) begin
            r_mem[i_q_ent.addr] <= i_q_ent.data;
        end
        if (pop_tick) begin
            r_a_rd <= r_mem[i_q_ent.addr];
        end
    end

    always_comb begin
        a_mag  = r_a_rd[SAMPLE_W-1] ? (MAG_W'(0) - {r_a_rd[SAMPLE_W-1], r_a_rd})
                                    : {1'b0, r_a_rd};
        a_prod = PROD_W'(a_mag) * PROD_W'(i_vol);
    end

    always_comb begin
        b_full   = r_b_prod * RECIP_100;
        b_quot   = b_full[RECIP_SHIFT +: SAMPLE_W];
        b_sample = r_b_neg ? (SAMPLE_W'(0) - b_quot) : b_quot;
        if (!r_b_flags.playing) begin
            b_sample = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_tick) begin
            r_a_flags.playing  <= i_q_ent.playing;
            r_a_flags.looping  <= i_q_ent.looping;
            r_a_flags.pass_end <= i_q_ent.pass_end;
        end
        if (r_a_valid && b_ready) begin
            r_b_prod  <= a_prod;
            r_b_neg   <= r_a_rd[SAMPLE_W-1];
            r_b_flags <= r_a_flags;
        end
        if (r_b_valid && o_ready) begin
            r_o_sample <= b_sample;
            r_o_flags  <= r_b_flags;
            r_o_amp    <= (i_vol != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= pop_tick;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (o_ready) begin
                r_o_valid <= r_b_valid;
            end
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_sample_out = r_o_sample;
    assign o_playing    = r_o_flags.playing;
    assign o_looping    = r_o_flags.looping;
    assign o_pass_end   = r_o_flags.pass_end;
    assign o_amp_enable = r_o_amp;

endmodule

`default_nettype wire

// File: design/clip_player_loop_resume.sv
// Top level of the clip player: volume register, front end, queue and back end.
// A tick result is registered in the queue, then in the back end's read, product and output stages.
// Throughput: one transaction per cycle while no stall holds the queue or the three-stage back end.
// Input stall rises only while the four-entry queue is full.
// Reset is synchronous and active low; it clears clip state and sets the volume to 100.
// The sample store is not cleared by reset and has no clearing pass.
`default_nettype none

module clip_player_loop_resume (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_stall,
    input  wire  [2:0]                   i_mode,
    input  wire  [cpl_pkg::FIELD_ADDR_W-1:0] i_start_addr,
    input  wire  [cpl_pkg::COUNT_W-1:0]  i_frame_count,
    input  wire  [cpl_pkg::SAMPLE_W-1:0] i_load_sample,
    input  wire                          i_cfg_we,
    input  wire  [cpl_pkg::VOL_W-1:0]    i_cfg_wdata,
    output logic                         o_out_valid,
    input  wire                          i_out_stall,
    output logic [cpl_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                         o_playing,
    output logic                         o_looping,
    output logic                         o_pass_end,
    output logic                         o_amp_enable
);
    import cpl_pkg::*;

    logic [VOL_W-1:0] r_vol;
    logic             q_full;
    logic             push;
    t_qent            push_ent;
    logic             pop;
    logic             q_valid;
    t_qent            q_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vol <= VOL_FULL;
        end else if (i_cfg_we) begin
            r_vol <= (i_cfg_wdata > VOL_FULL) ? VOL_FULL : i_cfg_wdata;
        end
    end

    cpl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_mode        (i_mode),
        .i_start_addr  (i_start_addr),
        .i_frame_count (i_frame_count),
        .i_load_sample (i_load_sample),
        .i_q_full      (q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_push_ent    (push_ent)
    );

    cpl_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_ent (push_ent),
        .o_full     (q_full),
        .i_pop      (pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    cpl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_ent      (q_head),
        .o_pop        (pop),
        .i_vol        (r_vol),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_playing    (o_playing),
        .o_looping    (o_looping),
        .o_pass_end   (o_pass_end),
        .o_amp_enable (o_amp_enable)
    );

endmodule

`default_nettype wire

// File: design/cpl_checker.sv
// Port-level checker for the clip player and its bind to the top level.
`default_nettype none

module cpl_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_out_valid,
    input wire        i_out_stall,
    input wire [15:0] o_sample_out,
    input wire        o_playing,
    input wire        o_looping,
    input wire        o_pass_end
);

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_playing) |-> (o_sample_out == 16'd0 && !o_looping && !o_pass_end))
        else $error("Idle tick transaction carries nonzero data.");

    a_end_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pass_end) |-> o_playing)
        else $error("Pass end flagged on a tick without an active clip.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_sample_out)))
        else $error("Stalled output transaction changed.");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("Output valid right after reset.");

endmodule

bind clip_player_loop_resume cpl_checker u_cpl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_sample_out (o_sample_out),
    .o_playing    (o_playing),
    .o_looping    (o_looping),
    .o_pass_end   (o_pass_end)
);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the clip player: a scoreboard model predicts every tick transaction.
`default_nettype none

module testbench;
    import cpl_pkg::*;

    localparam int SAT_HI      = 32767;
    localparam int SAT_LO      = -32768;
    localparam int MAX_WAIT    = 18;
    localparam int IDLE_LIMIT  = 2000;
    localparam int PHASE_ITEMS = 140;
    // Random clips stay inside a loaded window that wraps across the top of the store.
    localparam int WIN_BASE    = STORE_DEPTH - 32;
    localparam int WIN_SIZE    = 320;
    localparam logic [2:0] FIRST_UNUSED_MODE = 3'd5;
    localparam logic [2:0] LAST_UNUSED_MODE  = 3'd7;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                playing;
        logic                looping;
        logic                pass_end;
        logic                amp_en;
    } tick_out_t;

    class clip_scoreboard;
        logic [SAMPLE_W-1:0] sample_mem [STORE_DEPTH];
        t_addr               pos;
        logic [COUNT_W-1:0]  left;
        bit                  on_loop;
        t_addr               loop_addr;
        logic [COUNT_W-1:0]  loop_frames;
        bit                  loop_armed;
        bit                  loop_parked;
        int                  gain;
        tick_out_t           expected_ticks[$];
        int                  errors;

        function new();
            pos         = '0;
            left        = '0;
            on_loop     = 0;
            loop_addr   = '0;
            loop_frames = '0;
            loop_armed  = 0;
            loop_parked = 0;
            gain        = int'(VOL_FULL);
            errors      = 0;
        endfunction

        function void set_volume(int value);
            gain = (value > int'(VOL_FULL)) ? int'(VOL_FULL) : value;
        endfunction

        function void restart_loop();
            on_loop = 1;
            pos     = loop_addr;
            left    = loop_frames;
        endfunction

        function void note_input(logic [2:0] mode, t_addr addr, logic [COUNT_W-1:0] count,
                                 logic [SAMPLE_W-1:0] smp);
            tick_out_t r;
            int        s;
            case (mode)
                MODE_LOAD: sample_mem[addr] = smp;
                MODE_ONCE: if (count != 0) begin
                    if (loop_armed && !loop_parked) loop_parked = 1;
                    else loop_armed = 0;
                    on_loop = 0;
                    pos     = addr;
                    left    = count;
                end
                MODE_LOOP: if (count != 0) begin
                    loop_addr   = addr;
                    loop_frames = count;
                    loop_armed  = 1;
                    loop_parked = 0;
                    restart_loop();
                end
                MODE_STOP: begin
                    pos         = '0;
                    left        = '0;
                    on_loop     = 0;
                    loop_armed  = 0;
                    loop_parked = 0;
                end
                MODE_TICK: begin
                    r        = '0;
                    r.amp_en = (gain > 0);
                    if (left != 0) begin
                        s = $signed(sample_mem[pos]);
                        if (gain < int'(VOL_FULL)) s = s * gain / int'(VOL_FULL);
                        if (s > SAT_HI) s = SAT_HI;
                        else if (s < SAT_LO) s = SAT_LO;
                        r.sample   = s[SAMPLE_W-1:0];
                        r.playing  = 1;
                        r.looping  = on_loop;
                        r.pass_end = (left == 1);
                        pos  = pos + 1'b1;
                        left = left - 1'b1;
                        if (left == 0) begin
                            if (on_loop) begin
                                restart_loop();
                            end else if (loop_parked) begin
                                loop_parked = 0;
                                loop_armed  = 1;
                                restart_loop();
                            end
                        end
                    end
                    expected_ticks.push_back(r);
                end
                default: ;
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(tick_out_t got);
            tick_out_t want;
            if (expected_ticks.size() == 0) begin
                report_mismatch($sformatf("result with no tick pending, sample %0d",
                                          $signed(got.sample)));
                return;
            end
            want = expected_ticks.pop_front();
            if (got.sample !== want.sample)
                report_mismatch($sformatf("sample_out got %0d expected %0d",
                                          $signed(got.sample), $signed(want.sample)));
            if (got.playing !== want.playing)
                report_mismatch($sformatf("playing got %b expected %b", got.playing,
                                          want.playing));
            if (got.looping !== want.looping)
                report_mismatch($sformatf("looping got %b expected %b", got.looping,
                                          want.looping));
            if (got.pass_end !== want.pass_end)
                report_mismatch($sformatf("pass_end got %b expected %b", got.pass_end,
                                          want.pass_end));
            if (got.amp_en !== want.amp_en)
                report_mismatch($sformatf("amp_enable got %b expected %b", got.amp_en,
                                          want.amp_en));
        endtask
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_in_valid = 1'b0;
    logic [2:0]              i_mode = '0;
    logic [FIELD_ADDR_W-1:0] i_start_addr = '0;
    logic [COUNT_W-1:0]      i_frame_count = '0;
    logic [SAMPLE_W-1:0]     i_load_sample = '0;
    logic                    i_cfg_we = 1'b0;
    logic [VOL_W-1:0]        i_cfg_wdata = '0;
    logic                    i_out_stall = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic [SAMPLE_W-1:0]     o_sample_out;
    logic                    o_playing;
    logic                    o_looping;
    logic                    o_pass_end;
    logic                    o_amp_enable;

    clip_scoreboard sb = new();
    tick_out_t      seen;
    bit             in_idle_on = 1'b0;
    bit             out_idle_on = 1'b0;
    int             stall_left = 0;
    int             quiet_cycles = 0;
    int             items_sent = 0;

    clip_player_loop_resume dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_mode        (i_mode),
        .i_start_addr  (i_start_addr),
        .i_frame_count (i_frame_count),
        .i_load_sample (i_load_sample),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_out  (o_sample_out),
        .o_playing     (o_playing),
        .o_looping     (o_looping),
        .o_pass_end    (o_pass_end),
        .o_amp_enable  (o_amp_enable)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_mode, i_start_addr, i_frame_count, i_load_sample);
            if (o_out_valid && !i_out_stall) begin
                seen = {o_sample_out, o_playing, o_looping, o_pass_end, o_amp_enable};
                sb.check_result(seen);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall)
            stall_left = out_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        else if (stall_left > 0)
            stall_left--;
        i_out_stall <= (stall_left > 0);
    end

    initial begin
        wait (i_rst_n);
        while (quiet_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic send_cmd(input logic [2:0] mode, input t_addr addr,
                            input logic [COUNT_W-1:0] count, input logic [SAMPLE_W-1:0] smp);
        int gap;
        gap = in_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_start_addr  <= addr;
        i_frame_count <= count;
        i_load_sample <= smp;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (mode <= MODE_TICK && !((mode == MODE_ONCE || mode == MODE_LOOP) && count == 0))
            items_sent++;
    endtask

    task automatic send_tick();
        send_cmd(MODE_TICK, t_addr'($urandom), COUNT_W'($urandom_range(0, STORE_DEPTH)),
                 SAMPLE_W'($urandom));
    endtask

    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_ticks.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_gain(input logic [VOL_W-1:0] value);
        wait_results_done();
        repeat (6) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_volume(int'(value));
    endtask

    function automatic logic [COUNT_W-1:0] draw_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return COUNT_W'($urandom_range(1, WIN_SIZE));
        if (r < 5) return '0;
        return COUNT_W'($urandom_range(1, 24));
    endfunction

    function automatic t_addr pick_addr(input logic [COUNT_W-1:0] len);
        return t_addr'(WIN_BASE + int'($urandom_range(0, WIN_SIZE - int'(len))));
    endfunction

    task automatic run_loop_interrupt();
        logic [COUNT_W-1:0] loop_n;
        logic [COUNT_W-1:0] once_n;
        loop_n = COUNT_W'($urandom_range(1, 12));
        once_n = COUNT_W'($urandom_range(1, 8));
        send_cmd(MODE_LOOP, pick_addr(loop_n), loop_n, SAMPLE_W'($urandom));
        repeat ($urandom_range(0, loop_n + 2)) send_tick();
        send_cmd(MODE_ONCE, pick_addr(once_n), once_n, SAMPLE_W'($urandom));
        repeat ($urandom_range(0, once_n)) send_tick();
        if ($urandom_range(0, 2) == 0)
            send_cmd(MODE_ONCE, pick_addr(once_n), once_n, SAMPLE_W'($urandom));
        repeat (once_n + $urandom_range(0, 2 * loop_n)) send_tick();
        if ($urandom_range(0, 3) == 0)
            send_cmd(MODE_STOP, t_addr'($urandom), '0, SAMPLE_W'($urandom));
    endtask

    task automatic send_random_item();
        int                 r;
        logic [COUNT_W-1:0] n;
        r = $urandom_range(0, 99);
        if (r < 45)
            send_tick();
        else if (r < 60)
            send_cmd(MODE_LOAD, t_addr'($urandom), COUNT_W'($urandom_range(0, STORE_DEPTH)),
                     SAMPLE_W'($urandom));
        else if (r < 72) begin
            n = draw_len();
            send_cmd(MODE_ONCE, pick_addr(n), n, SAMPLE_W'($urandom));
        end else if (r < 82) begin
            n = draw_len();
            send_cmd(MODE_LOOP, pick_addr(n), n, SAMPLE_W'($urandom));
        end else if (r < 88)
            send_cmd(MODE_STOP, t_addr'($urandom), COUNT_W'($urandom_range(0, STORE_DEPTH)),
                     SAMPLE_W'($urandom));
        else if (r < 93)
            send_cmd(3'($urandom_range(FIRST_UNUSED_MODE, LAST_UNUSED_MODE)), t_addr'($urandom),
                     COUNT_W'($urandom_range(0, STORE_DEPTH)), SAMPLE_W'($urandom));
        else if (r < 99)
            send_tick();
        else
            wait_results_done();
    endtask

    initial begin
        logic [VOL_W-1:0]    gains [7];
        logic [SAMPLE_W-1:0] word;
        t_addr               ld_addr;
        int                  phase_end;
        int                  last_toggle;
        gains = '{VOL_W'(0), VOL_W'(1), VOL_W'(127), VOL_W'(99), VOL_W'(50),
                  VOL_W'($urandom_range(2, 98)), VOL_FULL};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_tick();
        send_cmd(FIRST_UNUSED_MODE, '0, '0, '0);
        send_cmd(LAST_UNUSED_MODE, '1, COUNT_W'(STORE_DEPTH), '1);
        send_cmd(MODE_ONCE, t_addr'(5), '0, '0);
        send_tick();
        send_cmd(MODE_LOOP, t_addr'(7), '0, '0);
        send_tick();

        for (int k = 0; k < WIN_SIZE; k++) begin
            if (k % 64 == 0) in_idle_on = $urandom_range(0, 1);
            if (k % 128 == 0) out_idle_on = $urandom_range(0, 1);
            ld_addr = t_addr'(WIN_BASE + k);
            case (ld_addr)
                t_addr'(0):               word = 16'h8000;
                t_addr'(1):               word = 16'h7FFF;
                t_addr'(2):               word = 16'h0000;
                t_addr'(STORE_DEPTH - 1): word = 16'hFFFF;
                default:                  word = SAMPLE_W'($urandom);
            endcase
            send_cmd(MODE_LOAD, ld_addr, COUNT_W'($urandom_range(0, STORE_DEPTH)), word);
        end

        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        send_cmd(MODE_ONCE, t_addr'(STORE_DEPTH - 2), COUNT_W'(4), '0);
        repeat (5) send_tick();
        send_cmd(MODE_LOOP, t_addr'(0), COUNT_W'(3), '0);
        repeat (2) send_tick();
        send_cmd(MODE_ONCE, t_addr'(STORE_DEPTH - 1), COUNT_W'(2), '0);
        send_tick();
        send_cmd(MODE_ONCE, t_addr'(1), COUNT_W'(1), '0);
        repeat (5) send_tick();
        send_cmd(MODE_STOP, '0, '0, '0);
        send_tick();
        send_cmd(MODE_ONCE, t_addr'(10), COUNT_W'(2), '0);
        repeat (3) send_tick();
        send_cmd(MODE_ONCE, '1, COUNT_W'(STORE_DEPTH), '1);
        repeat (2) send_tick();
        send_cmd(MODE_STOP, '0, '0, '0);

        foreach (gains[g]) begin
            set_gain(gains[g]);
            send_cmd(MODE_ONCE, t_addr'(0), COUNT_W'(4), '0);
            repeat (4) send_tick();
            phase_end   = items_sent + PHASE_ITEMS;
            last_toggle = items_sent;
            while (items_sent < phase_end) begin
                if (items_sent - last_toggle >= 64) begin
                    last_toggle = items_sent;
                    in_idle_on  = $urandom_range(0, 2) != 0;
                    out_idle_on = $urandom_range(0, 2) != 0;
                end
                if ($urandom_range(0, 99) < 35) run_loop_interrupt();
                else send_random_item();
            end
        end

        wait_results_done();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.expected_ticks.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

`default_nettype wire
